// ----- hdl/brht_pkg.sv -----
// types and codes shared by the byte range hole tracker modules
`default_nettype none
package brht_pkg;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  localparam logic [2:0] STS_DONE  = 3'd0;
  localparam logic [2:0] STS_ZERO  = 3'd1;
  localparam logic [2:0] STS_WRAP  = 3'd2;
  localparam logic [2:0] STS_FULL  = 3'd3;
  localparam logic [2:0] STS_INDEX = 3'd4;

  typedef struct packed {
    logic load;
    logic rd_scan;
    logic rd_entry;
    logic eval;
    logic tail;
    logic capture;
    logic finish;
    logic result;
  } brht_cmd_t;

  typedef struct packed {
    logic early;
    logic is_read;
    logic more;
    logic ins_need;
    logic tail_need;
  } brht_sts_t;

endpackage
`default_nettype wire

// ----- hdl/brht_req_if.sv -----
// request channel: operation and range
`default_nettype none
interface brht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] range_start;
  logic [63:0] range_length;
  logic [5:0]  entry_index;

  modport source (output valid, action, range_start, range_length, entry_index, input ready);
  modport sink (input valid, action, range_start, range_length, entry_index, output ready);
endinterface
`default_nettype wire

// ----- hdl/brht_rsp_if.sv -----
// response channel: status, count and read entry
`default_nettype none
interface brht_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        found;
  logic [6:0]  hole_count;
  logic [63:0] entry_start;
  logic [63:0] entry_length;

  modport source (output valid, status, found, hole_count, entry_start, entry_length,
                  input ready);
  modport sink (input valid, status, found, hole_count, entry_start, entry_length,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/byte_range_hole_tracker.sv -----
// byte range hole tracker top level
// Keeps a sorted table of disjoint, non-touching byte ranges.
// req_i (sink): action, range_start, range_length, entry_index; a transfer
//   happens when valid and ready are both high.
// rsp_o (source): status, found, hole_count, entry_start, entry_length;
//   exactly one response per request, in order.
// A rejected request goes from load through the scan state straight to the
//   done state, and a read reads one entry; add, remove and query scan the
//   table one entry at a time, a read then an evaluation for each, through
//   the single read port of the table memory, with an extra step for each
//   inserted or split entry.
// One request is worked on at a time; ready is high only while idle, so a
//   new request is taken at the earliest in the cycle after the response is set.
// A finished response waits in an output register; the next request is
//   taken meanwhile, and its response waits for that register to drain.
// Reset empties the table (count to zero); table contents are not cleared
//   and need no clearing pass, only entries below the count are ever read.
`default_nettype none
module byte_range_hole_tracker
  import brht_pkg::*;
#(
  parameter int MAX_HOLES = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  brht_req_if.sink    req_i,
  brht_rsp_if.source  rsp_o
);

  brht_cmd_t cmd;
  brht_sts_t sts;

  brht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brht_dp #(
    .MAX_HOLES (MAX_HOLES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (req_i.action),
    .range_start_i  (req_i.range_start),
    .range_length_i (req_i.range_length),
    .entry_index_i  (req_i.entry_index),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (rsp_o.status),
    .found_o        (rsp_o.found),
    .hole_count_o   (rsp_o.hole_count),
    .entry_start_o  (rsp_o.entry_start),
    .entry_length_o (rsp_o.entry_length)
  );

endmodule
`default_nettype wire

// ----- hdl/brht_dp.sv -----
// datapath: double-banked range table, scan counters and result registers
`default_nettype none
module brht_dp
  import brht_pkg::*;
#(
  parameter int MAX_HOLES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [1:0]  action_i,
  input  wire logic [63:0] range_start_i,
  input  wire logic [63:0] range_length_i,
  input  wire logic [5:0]  entry_index_i,
  input  wire brht_cmd_t   cmd_i,
  output brht_sts_t        sts_o,
  output logic [2:0]       status_o,
  output logic             found_o,
  output logic [6:0]       hole_count_o,
  output logic [63:0]      entry_start_o,
  output logic [63:0]      entry_length_o
);

  localparam int AW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int CW = $clog2(MAX_HOLES + 1);
  localparam int XW = (CW > 6) ? CW : 6;

  logic [127:0] mem [2**(AW+1)];

  logic [1:0]   act_q;
  logic [63:0]  f_q, l_q, nf_q, nl_q;
  logic [63:0]  ent_start_q, ent_len_q;
  logic [5:0]   idx_q;
  logic [2:0]   st_q;
  logic [CW-1:0] rd_q, wr_q, used_q, wr_d;
  logic         ins_q, lost_q, fnd_q, bank_q;
  logic [127:0] rdata_q;

  logic [63:0]  ef, el;
  logic         left, right, outside, full, is_add, is_rem, is_qry;
  logic         we;
  logic [127:0] wdata;
  logic [AW:0]  waddr, raddr;
  logic         rd_en;
  logic [64:0]  sum;
  logic [2:0]   st_d;
  logic         in_full, idx_ok;

  assign ef      = rdata_q[127:64];
  assign el      = rdata_q[63:0];
  assign is_add  = (act_q == ACT_ADD);
  assign is_rem  = (act_q == ACT_REMOVE);
  assign is_qry  = (act_q == ACT_QUERY);
  assign left    = ({1'b0, el} + 65'd1) < {1'b0, f_q};
  assign right   = {1'b0, ef} > ({1'b0, l_q} + 65'd1);
  assign outside = (el < f_q) || (ef > l_q);
  assign full    = (used_q >= CW'(MAX_HOLES));

  assign sts_o.early     = (st_q != STS_DONE);
  assign sts_o.is_read   = (act_q == ACT_READ);
  assign sts_o.more      = (rd_q < used_q);
  assign sts_o.ins_need  = is_add && right && !left && !ins_q;
  assign sts_o.tail_need = is_rem && !outside && (ef < f_q) && (el > l_q) && !full;

  // status known at load time
  assign sum     = {1'b0, range_start_i} + {1'b0, range_length_i};
  assign in_full = (used_q >= CW'(MAX_HOLES));
  assign idx_ok  = XW'(entry_index_i) < XW'(used_q);

  always_comb begin
    if (action_i == ACT_READ) begin
      st_d = idx_ok ? STS_DONE : STS_INDEX;
    end else if (range_length_i == 64'd0) begin
      st_d = STS_ZERO;
    end else if (sum[64]) begin
      st_d = STS_WRAP;
    end else if ((action_i == ACT_ADD) && in_full) begin
      st_d = STS_FULL;
    end else begin
      st_d = STS_DONE;
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = rdata_q;
    if (cmd_i.eval && is_add) begin
      if (left) begin
        we = 1'b1;
      end else if (right) begin
        we = 1'b1;
        if (!ins_q) wdata = {nf_q, nl_q};
      end
    end else if (cmd_i.eval && is_rem) begin
      if (outside) begin
        we = 1'b1;
      end else if (ef < f_q) begin
        we    = 1'b1;
        wdata = {ef, f_q - 64'd1};
      end else if (el > l_q) begin
        we    = 1'b1;
        wdata = {l_q + 64'd1, el};
      end
    end else if (cmd_i.tail) begin
      we    = 1'b1;
      wdata = {l_q + 64'd1, el};
    end else if (cmd_i.finish && is_add && !ins_q) begin
      we    = 1'b1;
      wdata = {nf_q, nl_q};
    end
  end

  assign wr_d  = wr_q + CW'(we);
  assign waddr = {~bank_q, wr_q[AW-1:0]};
  assign rd_en = cmd_i.rd_scan || cmd_i.rd_entry;
  assign raddr = cmd_i.rd_entry ? {bank_q, AW'(idx_q)} : {bank_q, rd_q[AW-1:0]};

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      bank_q <= 1'b0;
      rd_q   <= '0;
      wr_q   <= '0;
      ins_q  <= 1'b0;
      lost_q <= 1'b0;
      fnd_q  <= 1'b0;
      st_q   <= STS_DONE;
      act_q  <= ACT_ADD;
    end else if (cmd_i.load) begin
      act_q  <= action_i;
      st_q   <= st_d;
      rd_q   <= '0;
      wr_q   <= '0;
      ins_q  <= 1'b0;
      lost_q <= 1'b0;
      fnd_q  <= 1'b0;
    end else begin
      wr_q <= wr_d;
      if (cmd_i.eval) begin
        if (!sts_o.ins_need) rd_q <= rd_q + CW'(1);
        if (is_add && right && !ins_q) ins_q <= 1'b1;
        if (is_rem && !outside && (ef < f_q) && (el > l_q) && full) lost_q <= 1'b1;
        if (is_qry && (ef == f_q) && (el == l_q)) fnd_q <= 1'b1;
      end
      if (cmd_i.finish && (is_add || is_rem)) begin
        bank_q <= ~bank_q;
        used_q <= wr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      f_q   <= range_start_i;
      l_q   <= range_start_i + range_length_i - 64'd1;
      nf_q  <= range_start_i;
      nl_q  <= range_start_i + range_length_i - 64'd1;
      idx_q <= entry_index_i;
      ent_start_q <= '0;
      ent_len_q   <= '0;
    end else begin
      if (cmd_i.eval && is_add && !left && !right) begin
        if (ef < nf_q) nf_q <= ef;
        if (el > nl_q) nl_q <= el;
      end
      if (cmd_i.capture) begin
        ent_start_q <= ef;
        ent_len_q   <= el - ef + 64'd1;
      end
    end
    if (cmd_i.result) begin
      status_o       <= lost_q ? STS_FULL : st_q;
      found_o        <= fnd_q;
      hole_count_o   <= 7'(used_q);
      entry_start_o  <= ent_start_q;
      entry_length_o <= ent_len_q;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/brht_ctrl.sv -----
// controller: sequences load, table scan, commit and response transfer
`default_nettype none
module brht_ctrl
  import brht_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  wire logic      rsp_ready_i,
  input  wire brht_sts_t sts_i,
  output brht_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_RDENT = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       vld_q, vld_d;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = vld_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    vld_d   = vld_q && !rsp_ready_i;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.early) begin
          state_d = S_DONE;
        end else if (sts_i.is_read) begin
          cmd_o.rd_entry = 1'b1;
          state_d        = S_RDENT;
        end else if (sts_i.more) begin
          cmd_o.rd_scan = 1'b1;
          state_d       = S_EVAL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.ins_need) state_d = S_EVAL;
        else if (sts_i.tail_need) state_d = S_TAIL;
        else state_d = S_SCAN;
      end
      S_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d    = S_SCAN;
      end
      S_RDENT: begin
        cmd_o.capture = 1'b1;
        state_d       = S_DONE;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!vld_q || rsp_ready_i) begin
          cmd_o.result = 1'b1;
          vld_d        = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/brht_checker.sv -----
// port-level checks for the byte range hole tracker, bound to the top level
`default_nettype none
module brht_checker
  import brht_pkg::*;
#(
  parameter int MAX_HOLES = 64
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid_i,
  input wire logic        req_ready_i,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic [2:0]  status_i,
  input wire logic        found_i,
  input wire logic [6:0]  hole_count_i,
  input wire logic [63:0] entry_start_i,
  input wire logic [63:0] entry_length_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before transfer");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (MAX_HOLES > 64) || (hole_count_i <= 7'(MAX_HOLES)))
    else $error("hole count above table size");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STS_INDEX) |->
      (entry_start_i == 64'd0) && (entry_length_i == 64'd0))
    else $error("bad index returned entry data");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && found_i |-> (status_i == STS_DONE) && (hole_count_i != 7'd0))
    else $error("found with bad status or empty table");

endmodule

bind byte_range_hole_tracker brht_checker #(
  .MAX_HOLES (MAX_HOLES)
) u_brht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .found_i        (rsp_o.found),
  .hole_count_i   (rsp_o.hole_count),
  .entry_start_i  (rsp_o.entry_start),
  .entry_length_i (rsp_o.entry_length)
);
`default_nettype wire
